FILE: design/smppt_pkg.sv
`timescale 1ns / 1ps
package smppt_pkg;

    localparam int PIX_QBITS = 13;
    localparam int LINE_MAX  = 4095;

    typedef enum logic [1:0] {
        MODE_DEFAULT = 2'd0,
        MODE_SKIP    = 2'd1,
        MODE_SP8     = 2'd2,
        MODE_SP5     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_MARKER    = 3'd1,
        REG_LSTART    = 3'd2,
        REG_LSTOP     = 3'd3,
        REG_FRAMEMASK = 3'd4,
        REG_CHANMASK  = 3'd5,
        REG_PIXELS    = 3'd6,
        REG_DWELL     = 3'd7
    } reg_index_t;

    typedef struct packed {
        mode_t        reading_mode;
        logic [7:0]   marker_event_code;
        logic [15:0]  line_start_id;
        logic [15:0]  line_stop_id;
        logic [63:0]  frame_marker_mask;
        logic [63:0]  channel_mask;
        logic [12:0]  pixels_per_line;
        logic [31:0]  pixel_dwell;
    } cfg_t;

endpackage

FILE: design/smppt_fifo.sv
`timescale 1ns / 1ps
module smppt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule

FILE: design/smppt_front.sv
`timescale 1ns / 1ps
module smppt_front
    import smppt_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           event_kind,
    input  logic [7:0]           route,
    input  logic [47:0]          coarse_time,
    input  logic [15:0]          fine_time,
    input  logic                 job_full,
    output logic                 job_push,
    output logic [TIME_BITS-1:0] job_dt,
    output logic [15:0]          job_frame,
    output logic [11:0]          job_line,
    output logic [15:0]          job_fine,
    output logic [7:0]           job_route
);
    logic                 frame_seen_reg, frame_seen_next;
    logic                 line_open_reg, line_open_next;
    logic                 line_any_reg, line_any_next;
    logic [TIME_BITS-1:0] origin_reg, origin_next;
    logic [15:0]          frame_cnt_reg, frame_cnt_next;
    logic [11:0]          line_cnt_reg, line_cnt_next;

    logic                 accept, sp8, is_marker, frame_bit, start_frame, first;
    logic [15:0]          id;
    logic [63:0]          t_ext;
    logic [TIME_BITS-1:0] t;

    assign in_ready  = !job_full;
    assign accept    = in_valid && in_ready;
    assign sp8       = (cfg.reading_mode == MODE_SP8);
    assign is_marker = sp8 ? (route == cfg.marker_event_code)
                           : (event_kind == cfg.marker_event_code);
    assign id        = sp8 ? fine_time : {8'd0, route};
    assign frame_bit = (id < 16'd64) && cfg.frame_marker_mask[id[5:0]];
    assign t_ext     = 64'(coarse_time);
    assign t         = t_ext[TIME_BITS-1:0];

    assign job_dt    = t - origin_reg;
    assign job_frame = frame_cnt_reg;
    assign job_line  = line_cnt_reg;
    assign job_fine  = fine_time;
    assign job_route = route;

    always_comb begin
        frame_seen_next = frame_seen_reg;
        line_open_next  = line_open_reg;
        line_any_next   = line_any_reg;
        origin_next     = origin_reg;
        frame_cnt_next  = frame_cnt_reg;
        line_cnt_next   = line_cnt_reg;
        job_push        = 1'b0;
        start_frame     = 1'b0;
        first           = 1'b0;
        if (accept) begin
            if (!frame_seen_reg) begin
                first       = 1'b1;
                start_frame = (cfg.reading_mode == MODE_DEFAULT) || (is_marker && frame_bit);
            end else if (is_marker) begin
                priority if (id == cfg.line_start_id) begin
                    if (line_any_reg) begin
                        if (line_cnt_reg != 12'(LINE_MAX)) begin
                            line_cnt_next = line_cnt_reg + 1'b1;
                        end
                    end else begin
                        line_any_next = 1'b1;
                        line_cnt_next = '0;
                    end
                    line_open_next = 1'b1;
                    origin_next    = t;
                end else if (id == cfg.line_stop_id) begin
                    line_open_next = 1'b0;
                end else if (frame_bit) begin
                    start_frame = 1'b1;
                end else begin
                    start_frame = 1'b0;
                end
            end else begin
                job_push = (event_kind == 8'd0) && line_open_reg && (route < 8'd64)
                           && cfg.channel_mask[route[5:0]];
            end
        end
        if (start_frame) begin
            if (!first) begin
                frame_cnt_next = frame_cnt_reg + 1'b1;
            end
            frame_seen_next = 1'b1;
            line_open_next  = 1'b0;
            line_any_next   = 1'b0;
            line_cnt_next   = '0;
            // SP5: the frame marker doubles as the first line start
            if (cfg.reading_mode == MODE_SP5) begin
                line_open_next = 1'b1;
                line_any_next  = 1'b1;
                origin_next    = t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_seen_reg <= 1'b0;
            line_open_reg  <= 1'b0;
            line_any_reg   <= 1'b0;
            origin_reg     <= '0;
            frame_cnt_reg  <= '0;
            line_cnt_reg   <= '0;
        end else begin
            frame_seen_reg <= frame_seen_next;
            line_open_reg  <= line_open_next;
            line_any_reg   <= line_any_next;
            origin_reg     <= origin_next;
            frame_cnt_reg  <= frame_cnt_next;
            line_cnt_reg   <= line_cnt_next;
        end
    end
endmodule

FILE: design/smppt_back.sv
`timescale 1ns / 1ps
module smppt_back
    import smppt_pkg::*;
#(
    parameter int TIME_BITS       = 48,
    parameter int MAX_LINE_PIXELS = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [12:0]          pixels_per_line,
    input  logic [31:0]          pixel_dwell,
    input  logic                 job_empty,
    output logic                 job_pop,
    input  logic [TIME_BITS-1:0] job_dt,
    input  logic [15:0]          job_frame,
    input  logic [11:0]          job_line,
    input  logic [15:0]          job_fine,
    input  logic [7:0]           job_route,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          out_data
);
    localparam int NLIM_I = (MAX_LINE_PIXELS < 4096) ? MAX_LINE_PIXELS : 4096;
    localparam logic [PIX_QBITS-1:0] NLIM = PIX_QBITS'(NLIM_I);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_CHECK, ST_OUT} state_t;

    state_t                state_reg;
    logic [32:0]           rem_reg;
    logic [PIX_QBITS-1:0]  low_reg, quo_reg;
    logic [3:0]            step_reg;
    logic [31:0]           dwell_reg;
    logic [15:0]           frame_reg, fine_reg;
    logic [11:0]           line_reg;
    logic [7:0]            route_reg;

    logic [31:0]           dwell_eff;
    logic [63:0]           hi_ext;
    logic [32:0]           trial;
    logic                  ge;
    logic [PIX_QBITS-1:0]  n_eff;

    assign dwell_eff = (pixel_dwell == '0) ? 32'd1 : pixel_dwell;
    assign hi_ext    = 64'(job_dt[TIME_BITS-1:PIX_QBITS]);
    assign trial     = {rem_reg[31:0], low_reg[PIX_QBITS-1]};
    assign ge        = (trial >= {1'b0, dwell_reg});
    assign n_eff     = (pixels_per_line > NLIM) ? NLIM : pixels_per_line;
    assign job_pop   = (state_reg == ST_IDLE) && !job_empty;
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = {route_reg, fine_reg, quo_reg[11:0], line_reg, frame_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (!job_empty) begin
                        dwell_reg <= dwell_eff;
                        rem_reg   <= 33'(hi_ext);
                        low_reg   <= job_dt[PIX_QBITS-1:0];
                        frame_reg <= job_frame;
                        line_reg  <= job_line;
                        fine_reg  <= job_fine;
                        route_reg <= job_route;
                        step_reg  <= '0;
                        // quotient needs more bits than the line can hold: drop
                        if (hi_ext < 64'(dwell_eff)) begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg  <= ge ? (trial - {1'b0, dwell_reg}) : trial;
                    quo_reg  <= {quo_reg[PIX_QBITS-2:0], ge};
                    low_reg  <= {low_reg[PIX_QBITS-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'(PIX_QBITS - 1)) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    state_reg <= (quo_reg < n_eff) ? ST_OUT : ST_IDLE;
                end
                ST_OUT: begin
                    if (out_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: design/scan_marker_photon_pixel_tagger.sv
`timescale 1ns / 1ps
// Tags photon records of a laser-scanning acquisition with frame, line and pixel numbers.
// The front end takes one record per cycle, follows the frame and line markers and queues
// each enabled-channel photon that falls in an open line; it stalls only when the four-entry
// queue is full. The back end divides the time since line start by the pixel dwell one
// quotient bit per cycle and takes the next photon only when done with the last one.
// Configuration registers are written through cfg_wr_en / cfg_index / cfg_wr_data; the
// user must write them only while no photon is in flight: the block does not enforce it.
module scan_marker_photon_pixel_tagger
    import smppt_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int TIME_BITS       = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // route[7:0], coarse_time[55:8], fine_time[71:56]
    input  logic [7:0]  s_tuser,   // event_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // frame_index, line_index, pixel_index,
                                   // photon_fine_time, photon_route
);
    localparam int JOB_W = TIME_BITS + 16 + 12 + 16 + 8;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reading_mode      <= MODE_DEFAULT;
            cfg_reg.marker_event_code <= 8'd1;
            cfg_reg.line_start_id     <= 16'd1;
            cfg_reg.line_stop_id      <= 16'd2;
            cfg_reg.frame_marker_mask <= 64'd8;
            cfg_reg.channel_mask      <= 64'd1;
            cfg_reg.pixels_per_line   <= 13'd256;
            cfg_reg.pixel_dwell       <= 32'd1;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_MODE:      cfg_reg.reading_mode      <= mode_t'(cfg_wr_data[1:0]);
                REG_MARKER:    cfg_reg.marker_event_code <= cfg_wr_data[7:0];
                REG_LSTART:    cfg_reg.line_start_id     <= cfg_wr_data[15:0];
                REG_LSTOP:     cfg_reg.line_stop_id      <= cfg_wr_data[15:0];
                REG_FRAMEMASK: cfg_reg.frame_marker_mask <= cfg_wr_data;
                REG_CHANMASK:  cfg_reg.channel_mask      <= cfg_wr_data;
                REG_PIXELS:    cfg_reg.pixels_per_line   <= cfg_wr_data[12:0];
                REG_DWELL:     cfg_reg.pixel_dwell       <= cfg_wr_data[31:0];
                default:       cfg_reg.pixel_dwell       <= cfg_reg.pixel_dwell;
            endcase
        end
    end

    logic                 job_push, job_pop, job_full, job_empty;
    logic [TIME_BITS-1:0] f_dt, b_dt;
    logic [15:0]          f_frame, b_frame, f_fine, b_fine;
    logic [11:0]          f_line, b_line;
    logic [7:0]           f_route, b_route;
    logic [JOB_W-1:0]     wr_job, rd_job;

    smppt_front #(.TIME_BITS(TIME_BITS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .event_kind  (s_tuser),
        .route       (s_tdata[7:0]),
        .coarse_time (s_tdata[55:8]),
        .fine_time   (s_tdata[71:56]),
        .job_full    (job_full),
        .job_push    (job_push),
        .job_dt      (f_dt),
        .job_frame   (f_frame),
        .job_line    (f_line),
        .job_fine    (f_fine),
        .job_route   (f_route)
    );

    assign wr_job = {f_dt, f_frame, f_line, f_fine, f_route};
    assign {b_dt, b_frame, b_line, b_fine, b_route} = rd_job;

    smppt_fifo #(.WIDTH(JOB_W), .DEPTH(4)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .wr_data (wr_job),
        .pop     (job_pop),
        .rd_data (rd_job),
        .full    (job_full),
        .empty   (job_empty)
    );

    smppt_back #(.TIME_BITS(TIME_BITS), .MAX_LINE_PIXELS(MAX_LINE_PIXELS)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pixels_per_line (cfg_reg.pixels_per_line),
        .pixel_dwell     (cfg_reg.pixel_dwell),
        .job_empty       (job_empty),
        .job_pop         (job_pop),
        .job_dt          (b_dt),
        .job_frame       (b_frame),
        .job_line        (b_line),
        .job_fine        (b_fine),
        .job_route       (b_route),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_data        (m_tdata)
    );
endmodule
